FILE: design/cdll_pkg.sv
// Package with shared types and constants of the circular doubly linked list.
`default_nettype none

package cdll_pkg;

  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 6;
  localparam int VALUE_W   = 32;
  // A dump never gives more results than this.
  localparam int RESULT_LIMIT = 32;

  localparam logic [REQ_W-1:0] REQ_APPEND    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP_FWD  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DUMP_BACK = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SET_STATUS,
    OP_APP_FIRST,
    OP_APP_READ_HEAD,
    OP_APP_LINK1,
    OP_APP_LINK2,
    OP_DEL_START,
    OP_DEL_STEP,
    OP_DEL_UNLINK,
    OP_DUMP_START,
    OP_DUMP_TAIL,
    OP_DUMP_EMIT,
    OP_EMIT_STATUS
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [STATUS_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             list_empty;
    logic             list_full;
    logic             match;
    logic             walk_last;
    logic             dump_last;
    logic             out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: design/cdll_datapath.sv
// Datapath of the linked list: node memories, list registers and result register.
`default_nettype none

module cdll_datapath
  import cdll_pkg::*;
#(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cmd_t                       cmd,
  output stat_t                           stat,
  input  wire logic [REQ_W-1:0]           req_type,
  input  wire logic signed [VALUE_W-1:0]  value,
  input  wire logic                       rsp_stall,
  output logic                            rsp_valid,
  output logic [STATUS_W-1:0]             status,
  output logic                            item_valid,
  output logic signed [VALUE_W-1:0]       item_value,
  output logic                            last,
  output logic [COUNT_W-1:0]              count
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int LIM = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;

  // Node memories.
  logic signed [DATA_WIDTH-1:0] val_mem  [CAPACITY];
  logic        [IW-1:0]         next_mem [CAPACITY];
  logic        [IW-1:0]         prev_mem [CAPACITY];

  logic signed [DATA_WIDTH-1:0] val_rd;
  logic        [IW-1:0]         next_rd;
  logic        [IW-1:0]         prev_rd;

  // List and request registers.
  logic [REQ_W-1:0]             req;
  logic signed [DATA_WIDTH-1:0] key;
  logic [IW-1:0]                head;
  logic [CW-1:0]                elem_count;
  logic [CAPACITY-1:0]          used;
  logic [IW-1:0]                cur;
  logic [CW-1:0]                walk_i;
  logic [STATUS_W-1:0]          code;

  logic [IW-1:0]   free_slot;
  logic [CW-1:0]   dump_n;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            val_we;
  logic            next_we;
  logic [IW-1:0]   next_wa;
  logic [IW-1:0]   next_wd;
  logic            prev_we;
  logic [IW-1:0]   prev_wa;
  logic [IW-1:0]   prev_wd;

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int s = CAPACITY - 1; s >= 0; s--) begin
      if (!used[s]) begin
        free_slot = IW'(s);
      end
    end
  end

  assign dump_n = (elem_count > CW'(LIM)) ? CW'(LIM) : elem_count;

  assign stat.req        = req;
  assign stat.list_empty = (elem_count == '0);
  assign stat.list_full  = (elem_count == CW'(CAPACITY));
  assign stat.match      = (val_rd == key);
  assign stat.walk_last  = ((walk_i + CW'(1)) == elem_count);
  assign stat.dump_last  = ((walk_i + CW'(1)) == dump_n);
  assign stat.out_free   = !rsp_valid || !rsp_stall;

  // Read and write port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    val_we  = 1'b0;
    next_we = 1'b0;
    next_wa = free_slot;
    next_wd = free_slot;
    prev_we = 1'b0;
    prev_wa = free_slot;
    prev_wd = free_slot;
    unique case (cmd.op)
      OP_APP_READ_HEAD, OP_DEL_START, OP_DUMP_START: begin
        rd_en   = 1'b1;
        rd_addr = head;
      end
      OP_DEL_STEP: begin
        rd_en   = 1'b1;
        rd_addr = next_rd;
      end
      OP_DUMP_TAIL: begin
        rd_en   = 1'b1;
        rd_addr = prev_rd;
      end
      OP_DUMP_EMIT: begin
        rd_en   = 1'b1;
        rd_addr = (req == REQ_DUMP_BACK) ? prev_rd : next_rd;
      end
      OP_APP_FIRST: begin
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      OP_APP_LINK1: begin
        // New node points to head and to the old tail, read at head.
        val_we  = 1'b1;
        next_we = 1'b1;
        next_wd = head;
        prev_we = 1'b1;
        prev_wd = prev_rd;
      end
      OP_APP_LINK2: begin
        next_we = 1'b1;
        next_wa = prev_rd;
        next_wd = free_slot;
        prev_we = 1'b1;
        prev_wa = head;
        prev_wd = free_slot;
      end
      OP_DEL_UNLINK: begin
        next_we = 1'b1;
        next_wa = prev_rd;
        next_wd = next_rd;
        prev_we = 1'b1;
        prev_wa = next_rd;
        prev_wd = prev_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[free_slot] <= key;
    end
    if (rd_en) begin
      val_rd <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (rd_en) begin
      next_rd <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (rd_en) begin
      prev_rd <= prev_mem[rd_addr];
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        req <= req_type;
        key <= DATA_WIDTH'(64'(value));
      end
      OP_SET_STATUS: begin
        code <= cmd.code;
      end
      OP_APP_FIRST, OP_APP_LINK2, OP_DEL_UNLINK: begin
        code <= ST_OK;
      end
      OP_DEL_START: begin
        cur    <= head;
        walk_i <= '0;
      end
      OP_DEL_STEP: begin
        cur    <= next_rd;
        walk_i <= walk_i + CW'(1);
      end
      OP_DUMP_START: begin
        walk_i <= '0;
      end
      OP_DUMP_EMIT: begin
        walk_i     <= walk_i + CW'(1);
        status     <= ST_OK;
        item_valid <= 1'b1;
        item_value <= VALUE_W'(64'(val_rd));
        last       <= stat.dump_last;
        count      <= COUNT_W'(elem_count);
      end
      OP_EMIT_STATUS: begin
        status     <= code;
        item_valid <= 1'b0;
        item_value <= '0;
        last       <= 1'b1;
        count      <= COUNT_W'(elem_count);
      end
      default: begin
      end
    endcase
  end

  // List control registers and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      elem_count <= '0;
      used       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // A new result is loaded only when the register is free or drains now.
      if (cmd.op == OP_DUMP_EMIT || cmd.op == OP_EMIT_STATUS) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_APP_FIRST: begin
          head            <= free_slot;
          used[free_slot] <= 1'b1;
          elem_count      <= elem_count + CW'(1);
        end
        OP_APP_LINK2: begin
          used[free_slot] <= 1'b1;
          elem_count      <= elem_count + CW'(1);
        end
        OP_DEL_UNLINK: begin
          used[cur]  <= 1'b0;
          elem_count <= elem_count - CW'(1);
          if (elem_count == CW'(1)) begin
            head <= '0;
          end else if (cur == head) begin
            head <= next_rd;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(elem_count))
    else $error("element count differs from number of slots in use");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    elem_count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (rst)
    (elem_count == '0) |-> (head == '0))
    else $error("head not at zero on empty list");

  a_item_is_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && item_valid) |-> (status == ST_OK))
    else $error("dumped element without ok status");

endmodule

`default_nettype wire

FILE: design/cdll_controller.sv
// Controller state machine that sequences each request through the datapath.
`default_nettype none

module cdll_controller
  import cdll_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  output logic       req_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_APP_LINK1,
    S_APP_LINK2,
    S_DEL_WALK,
    S_DEL_UNLINK,
    S_DUMP_TAIL,
    S_DUMP_WALK,
    S_RESPOND
  } state_t;

  state_t state;
  state_t state_next;
  logic   req_stall_next;

  always_comb begin
    state_next     = state;
    req_stall_next = req_stall;
    cmd.op         = OP_NONE;
    cmd.code       = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (req_valid && !req_stall) begin
          cmd.op         = OP_LATCH;
          state_next     = S_DISPATCH;
          req_stall_next = 1'b1;
        end
      end
      S_DISPATCH: begin
        priority if (stat.req == REQ_APPEND) begin
          priority if (stat.list_full) begin
            cmd.op     = OP_SET_STATUS;
            cmd.code   = ST_FULL;
            state_next = S_RESPOND;
          end else if (stat.list_empty) begin
            cmd.op     = OP_APP_FIRST;
            state_next = S_RESPOND;
          end else begin
            cmd.op     = OP_APP_READ_HEAD;
            state_next = S_APP_LINK1;
          end
        end else if (stat.list_empty) begin
          cmd.op     = OP_SET_STATUS;
          cmd.code   = ST_EMPTY;
          state_next = S_RESPOND;
        end else if (stat.req == REQ_DELETE) begin
          cmd.op     = OP_DEL_START;
          state_next = S_DEL_WALK;
        end else begin
          cmd.op     = OP_DUMP_START;
          state_next = (stat.req == REQ_DUMP_BACK) ? S_DUMP_TAIL : S_DUMP_WALK;
        end
      end
      S_APP_LINK1: begin
        cmd.op     = OP_APP_LINK1;
        state_next = S_APP_LINK2;
      end
      S_APP_LINK2: begin
        cmd.op     = OP_APP_LINK2;
        state_next = S_RESPOND;
      end
      S_DEL_WALK: begin
        priority if (stat.match) begin
          state_next = S_DEL_UNLINK;
        end else if (stat.walk_last) begin
          cmd.op     = OP_SET_STATUS;
          cmd.code   = ST_NOT_FOUND;
          state_next = S_RESPOND;
        end else begin
          cmd.op = OP_DEL_STEP;
        end
      end
      S_DEL_UNLINK: begin
        cmd.op     = OP_DEL_UNLINK;
        state_next = S_RESPOND;
      end
      S_DUMP_TAIL: begin
        cmd.op     = OP_DUMP_TAIL;
        state_next = S_DUMP_WALK;
      end
      S_DUMP_WALK: begin
        if (stat.out_free) begin
          cmd.op = OP_DUMP_EMIT;
          if (stat.dump_last) begin
            state_next     = S_IDLE;
            req_stall_next = 1'b0;
          end
        end
      end
      S_RESPOND: begin
        if (stat.out_free) begin
          cmd.op         = OP_EMIT_STATUS;
          state_next     = S_IDLE;
          req_stall_next = 1'b0;
        end
      end
      default: begin
        state_next     = S_IDLE;
        req_stall_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_stall <= 1'b0;
    end else begin
      state     <= state_next;
      req_stall <= req_stall_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/circular_doubly_linked_list.sv
// Top level of the circular doubly linked list: controller and datapath.
//
// Usage: a request enters on the req channel (req_valid, req_stall, req_type, value)
// and is accepted at a clock edge with req_valid high and req_stall low. Results
// leave on the rsp channel (rsp_valid, rsp_stall and the result fields), one
// result per accepted edge with rsp_valid high and rsp_stall low.
// The block works on one request at a time. An append on a full or empty list
// goes straight to its result; otherwise it reads the head and then links the
// new node. A delete walks the list, and the search reads one linked node per
// cycle from the node memories. A dump reads the head, and for a backward dump
// the tail, then gives one element per cycle while the receiver does not stall;
// the memory read port sets that pace. The next request is taken once the final
// result of the current one sits in the output register, so one result may still
// be waiting while work goes on. When the receiver stalls, the result register
// holds its contents and the dump walk pauses with the read data held. Reset
// empties the list: the count, the head and the slot-in-use bits clear, and no
// memory clearing pass is needed because only linked slots are ever read.
`default_nettype none

module circular_doubly_linked_list
  import cdll_pkg::*;
#(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire logic [REQ_W-1:0]          req_type,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output logic [STATUS_W-1:0]            status,
  output logic                           item_valid,
  output logic signed [VALUE_W-1:0]      item_value,
  output logic                           last,
  output logic [COUNT_W-1:0]             count
);

  // Commands flow from the controller, status flows back from the datapath.
  cmd_t  cmd;
  stat_t stat;

  cdll_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cdll_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .value      (value),
    .rsp_stall  (rsp_stall),
    .rsp_valid  (rsp_valid),
    .status     (status),
    .item_valid (item_valid),
    .item_value (item_value),
    .last       (last),
    .count      (count)
  );

endmodule

`default_nettype wire
